/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the matrix multiplier.
// Both macros check on the rising clock edge. The first one is disabled
// while the active-low reset is asserted. The second one checks during
// reset as well.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define IMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/imm_pkg.sv */
// ---------------------------------------------------------------------------
// imm_pkg
// Types and fixed constants of the integer matrix multiplier.
// ---------------------------------------------------------------------------
package imm_pkg;

    localparam int unsigned IDX_W       = 3;   // row / column index width
    localparam int unsigned DIM_W       = 4;   // dimension register width
    localparam int unsigned VAL_W       = 32;  // element and result width
    localparam int unsigned IN_TDATA_W  = 72;  // row, col, a, b, zero fill
    localparam int unsigned OUT_TDATA_W = 40;  // row, col, product, zero fill
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Control from the sequencer to the multiply-accumulate datapath.
    typedef struct packed {
        logic rd_v;   // memory read data valid this cycle
        logic clear;  // zero the accumulator
    } t_mac_ctrl;

endpackage

/* rtl/core/imm_ram.sv */
// ---------------------------------------------------------------------------
// imm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No reset of the contents.
// ---------------------------------------------------------------------------
module imm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/imm_mac.sv */
// ---------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate datapath: registered signed product, then a wide
// exact accumulator; reports the low 32 bits and a signed overflow flag.
// ---------------------------------------------------------------------------
module imm_mac #(
    parameter int unsigned ELEM_WIDTH = 32,
    parameter int unsigned MAX_DIM    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imm_pkg::t_mac_ctrl            i_ctrl,
    input  logic signed [ELEM_WIDTH-1:0]  i_a,
    input  logic signed [ELEM_WIDTH-1:0]  i_b,
    output logic                          o_busy,
    output logic [imm_pkg::VAL_W-1:0]     o_sum,
    output logic                          o_ovf
);

    localparam int unsigned PROD_W = 2 * ELEM_WIDTH;
    localparam int unsigned SUM_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int unsigned ACC_W  = (SUM_W > imm_pkg::VAL_W + 1) ? SUM_W
                                                                   : imm_pkg::VAL_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_mul_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-imm_pkg::VAL_W:0] acc_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else begin
            r_mul_v <= i_ctrl.rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Exact sum fits 32-bit signed when all bits from 31 up agree.
    assign acc_top = r_acc[ACC_W-1:imm_pkg::VAL_W-1];
    assign o_ovf   = !((&acc_top) || !(|acc_top));
    assign o_sum   = r_acc[imm_pkg::VAL_W-1:0];
    assign o_busy  = r_mul_v;

endmodule

/* rtl/core/integer_matrix_multiply.sv */
// ---------------------------------------------------------------------------
// integer_matrix_multiply
// Square integer matrix product C = A x B with a dimension of 1..MAX_DIM.
// Load beats write one element of A and of B into two element RAMs; the
// beat flagged tlast starts the product, which streams C out row-major.
//
//   Channel  | Dir | Handshake                    | Payload
//   ---------+-----+------------------------------+---------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready | row, col, a, b; tlast=done
//   m_axis   | out | m_axis_tvalid / m_axis_tready | row, col, sum; tuser=ovf,
//            |     |                               | tlast=last element
//   cfg      | in  | i_cfg_wr_en (no wait)         | dimension, 4 bits
//
// Load beats are accepted back to back while idle. Each C element issues
// n reads of the two element RAMs, which feed one multiplier, then drains
// the read, multiply and accumulate stages and hands the sum to the output
// register; output stalls lengthen a run.
// Reset: control state clears synchronously; the element RAMs are not cleared
// and read undefined until loaded. A stalled output holds the sequencer in
// its emit state; the input stays closed until the whole run has been
// handed to the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_matrix_multiply #(
    parameter int unsigned MAX_DIM    = 8,
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: dimension register
    input  logic                               i_cfg_wr_en,
    input  logic [imm_pkg::DIM_W-1:0]          i_cfg_wr_data,
    // load beats
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] row_index, [5:3] col_index, [37:6] a_value, [69:38] b_value,
    // [71:70] zero
    input  logic [imm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,   // load_done
    // product beats
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] out_row, [5:3] out_col, [37:6] product_value, [39:38] zero
    output logic [imm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser,   // [0] overflow
    output logic                               m_axis_tlast    // last_out
);

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LIN_W = 2 * imm_pkg::IDX_W + 1;

    // -----------------------------------------------------------------
    // Input payload
    // -----------------------------------------------------------------
    logic [imm_pkg::IDX_W-1:0] in_row;
    logic [imm_pkg::IDX_W-1:0] in_col;
    logic [imm_pkg::VAL_W-1:0] in_a;
    logic [imm_pkg::VAL_W-1:0] in_b;

    assign in_row = s_axis_tdata[2:0];
    assign in_col = s_axis_tdata[5:3];
    assign in_a   = s_axis_tdata[37:6];
    assign in_b   = s_axis_tdata[69:38];

    // -----------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------
    imm_pkg::t_state           r_state, n_state;
    logic [imm_pkg::DIM_W-1:0] r_dim;
    logic [imm_pkg::DIM_W-1:0] r_n;
    logic [imm_pkg::IDX_W-1:0] r_i, r_j, r_k;
    logic                      r_rd_v;
    logic                      r_out_valid;
    logic [imm_pkg::IDX_W-1:0] r_out_row, r_out_col;
    logic [imm_pkg::VAL_W-1:0] r_out_val;
    logic                      r_out_ovf;
    logic                      r_out_last;

    logic                      in_acc;
    logic                      start;
    logic                      issue;
    logic                      out_free;
    logic                      out_load;
    logic [imm_pkg::DIM_W-1:0] act_n;
    logic [imm_pkg::DIM_W-1:0] n_last;
    logic [imm_pkg::DIM_W-1:0] k_ext;
    logic                      k_last, i_last, j_last, elem_last;
    logic                      in_range;
    logic [LIN_W-1:0]          w_lin, a_lin, b_lin;
    logic [ELEM_WIDTH-1:0]     a_rdata, b_rdata;
    logic                      mac_busy;
    logic [imm_pkg::VAL_W-1:0] mac_sum;
    logic                      mac_ovf;
    imm_pkg::t_mac_ctrl        mac_ctrl;

    // Clamp the dimension: zero runs as one, above MAX_DIM runs as MAX_DIM.
    always_comb begin
        if (r_dim == '0) begin
            act_n = imm_pkg::DIM_W'(1);
        end else if (r_dim > imm_pkg::DIM_W'(MAX_DIM)) begin
            act_n = imm_pkg::DIM_W'(MAX_DIM);
        end else begin
            act_n = r_dim;
        end
    end

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign start     = in_acc && s_axis_tlast;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign n_last    = r_n - imm_pkg::DIM_W'(1);
    assign k_ext     = imm_pkg::DIM_W'(r_k);
    assign k_last    = (k_ext == n_last);
    assign i_last    = (imm_pkg::DIM_W'(r_i) == n_last);
    assign j_last    = (imm_pkg::DIM_W'(r_j) == n_last);
    assign elem_last = i_last && j_last;

    // Loads outside the MAX_DIM square write nothing.
    assign in_range = (imm_pkg::DIM_W'(in_row) < imm_pkg::DIM_W'(MAX_DIM)) &&
                      (imm_pkg::DIM_W'(in_col) < imm_pkg::DIM_W'(MAX_DIM));

    assign w_lin = LIN_W'(in_row) * LIN_W'(MAX_DIM) + LIN_W'(in_col);
    assign a_lin = LIN_W'(r_i) * LIN_W'(MAX_DIM) + LIN_W'(r_k);
    assign b_lin = LIN_W'(r_k) * LIN_W'(MAX_DIM) + LIN_W'(r_j);

    // -----------------------------------------------------------------
    // Sequencer: next state
    // -----------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imm_pkg::S_IDLE: begin
                if (start) begin
                    n_state = imm_pkg::S_ISSUE;
                end
            end
            imm_pkg::S_ISSUE: begin
                if (k_last) begin
                    n_state = imm_pkg::S_DRAIN;
                end
            end
            imm_pkg::S_DRAIN: begin
                if (!r_rd_v && !mac_busy) begin
                    n_state = imm_pkg::S_EMIT;
                end
            end
            imm_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = elem_last ? imm_pkg::S_IDLE : imm_pkg::S_ISSUE;
                end
            end
            default: n_state = imm_pkg::S_IDLE;
        endcase
    end

    // -----------------------------------------------------------------
    // Sequencer: outputs
    // -----------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            imm_pkg::S_IDLE:  s_axis_tready = 1'b1;
            imm_pkg::S_ISSUE: issue         = 1'b1;
            imm_pkg::S_DRAIN: issue         = 1'b0;
            imm_pkg::S_EMIT:  out_load      = out_free;
            default:          issue         = 1'b0;
        endcase
    end

    // Zero the accumulator at the start of a run and after each handoff.
    assign mac_ctrl.rd_v  = r_rd_v;
    assign mac_ctrl.clear = start || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imm_pkg::S_IDLE;
            r_dim       <= imm_pkg::DIM_RESET;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_n         <= imm_pkg::DIM_RESET;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            if (i_cfg_wr_en) begin
                r_dim <= i_cfg_wr_data;
            end
            // Latch the run dimension and restart the counters.
            if (start) begin
                r_n <= act_n;
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            // Advance the inner-product index.
            if (issue) begin
                r_k <= k_last ? '0 : r_k + imm_pkg::IDX_W'(1);
            end
            // Advance to the next element in row-major order.
            if (out_load) begin
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + imm_pkg::IDX_W'(1);
                end else begin
                    r_j <= r_j + imm_pkg::IDX_W'(1);
                end
            end
            // Hold the result until the sink takes it.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row  <= r_i;
            r_out_col  <= r_j;
            r_out_val  <= mac_sum;
            r_out_ovf  <= mac_ovf;
            r_out_last <= elem_last;
        end
    end

    // -----------------------------------------------------------------
    // Element stores. Writes happen only while idle, and the first read
    // of a run is issued the cycle after the last write, so no forwarding
    // is needed.
    // -----------------------------------------------------------------
    imm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && in_range),
        .i_waddr (w_lin[AW-1:0]),
        .i_wdata (in_a[ELEM_WIDTH-1:0]),
        .i_raddr (a_lin[AW-1:0]),
        .o_rdata (a_rdata)
    );

    imm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && in_range),
        .i_waddr (w_lin[AW-1:0]),
        .i_wdata (in_b[ELEM_WIDTH-1:0]),
        .i_raddr (b_lin[AW-1:0]),
        .o_rdata (b_rdata)
    );

    imm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .MAX_DIM    (MAX_DIM)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     (a_rdata),
        .i_b     (b_rdata),
        .o_busy  (mac_busy),
        .o_sum   (mac_sum),
        .o_ovf   (mac_ovf)
    );

    // -----------------------------------------------------------------
    // Output port
    // -----------------------------------------------------------------
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_val, r_out_col, r_out_row};
    assign m_axis_tuser  = r_out_ovf;
    assign m_axis_tlast  = r_out_last;

    // -----------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------
    `IMM_ASSERT(a_emit_drained, i_clk, i_rst_n, r_state == imm_pkg::S_EMIT |-> !r_rd_v && !mac_busy, "sum handed off before the pipeline drained")
    `IMM_ASSERT(a_k_bound, i_clk, i_rst_n, r_state == imm_pkg::S_ISSUE |-> k_ext < r_n, "inner index beyond run dimension")
    `IMM_ASSERT(a_start_issue, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> r_state == imm_pkg::S_ISSUE && r_k == '0, "run did not start after the final load")
    `IMM_ASSERT(a_last_idle, i_clk, i_rst_n, out_load && elem_last |=> r_state == imm_pkg::S_IDLE && m_axis_tvalid && m_axis_tlast, "final element not flagged or run not closed")

endmodule

/* test/integer_matrix_multiply_test.sv */
// ---------------------------------------------------------------------------
// integer_matrix_multiply_test
// Self-checking bench for the integer matrix multiplier. Load beats come
// from a queue that an initial block fills with a short directed section
// (field extremes, overflow edges, dimension zero, loads outside the active
// dimension) followed by random runs, some with out-of-range settings. A
// predictor mirrors the element RAMs and the dimension register and queues
// the expected product beats, which the monitor checks field by field.
// Both sides idle at random, the receiver twice holds off for a long stretch,
// and the sender drains every result before each dimension change.
// ---------------------------------------------------------------------------
module integer_matrix_multiply_test;

    localparam int RANDOM_ITEMS  = 420;      // load beats in the random section
    localparam int SETTLE_CYCLES = 8;        // idle cycles before a dimension write
    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES  = 40;       // quiet cycles at the end
    localparam int CYCLE_LIMIT   = 3000000;  // timeout

    // value mixes for the element contents of one run
    typedef enum int {
        FILL_SMALL,
        FILL_FULL,
        FILL_EDGE
    } t_fill;

    // one entry of the stimulus queue: a load beat or a dimension write
    typedef struct {
        bit                          is_cfg;
        logic [imm_pkg::DIM_W-1:0]   dim_val;
        logic [imm_pkg::IDX_W-1:0]   row;
        logic [imm_pkg::IDX_W-1:0]   col;
        logic [imm_pkg::VAL_W-1:0]   a;
        logic [imm_pkg::VAL_W-1:0]   b;
        logic                        done;
    } t_load;

    // one expected element of C
    typedef struct {
        logic [imm_pkg::IDX_W-1:0]   row;
        logic [imm_pkg::IDX_W-1:0]   col;
        logic [imm_pkg::VAL_W-1:0]   value;
        logic                        ovf;
        logic                        last;
    } t_product;

    // DUT ports
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [imm_pkg::DIM_W-1:0]       i_cfg_wr_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [imm_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [imm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    // stimulus and prediction
    t_load                           load_q[$];      // beats and writes still to send
    t_product                        product_q[$];   // products still to arrive
    t_load                           cur_load;       // beat currently offered
    logic [imm_pkg::VAL_W-1:0]       a_mem [64];     // predicted element RAM of A
    logic [imm_pkg::VAL_W-1:0]       b_mem [64];     // predicted element RAM of B
    logic [imm_pkg::DIM_W-1:0]       dim_reg = imm_pkg::DIM_RESET;

    // planning state: which elements the queue has written so far
    bit                              planned [64];
    logic [imm_pkg::DIM_W-1:0]       plan_dim = imm_pkg::DIM_RESET;
    int                              n_loads;

    // handshake bookkeeping between the clock edges
    bit                              load_taken;
    bit                              product_taken;
    bit                              tx_burst;
    bit                              rx_burst;
    int                              tx_gap;
    int                              rx_gap;
    int                              settle_cnt;
    int                              hold_left;
    int                              hold_beats;
    int                              fail_count;
    int                              cycle_cnt;

    integer_matrix_multiply u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [2:0] row_index, [5:3] col_index, [37:6] a_value, [69:38] b_value
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),     // load_done
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [2:0] out_row, [5:3] out_col, [37:6] product_value
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),     // [0] overflow
        .m_axis_tlast  (m_axis_tlast)      // last_out
    );

    always #6 i_clk = ~i_clk;

    // Clamp the register value to the dimension the block works with.
    function automatic int eff_dim(input logic [imm_pkg::DIM_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (v > 8) begin
            return 8;
        end
        return int'(v);
    endfunction

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [imm_pkg::VAL_W-1:0] rand_elem(input t_fill fill);
        int pick;
        pick = $urandom_range(0, 5);
        case (fill)
            FILL_SMALL: begin
                return imm_pkg::VAL_W'(int'($urandom_range(0, 16)) - 8);
            end
            FILL_FULL: begin
                return $urandom();
            end
            default: begin
                case (pick)
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hffff_ffff;
                    3:       return 32'h7fff_ffff;
                    4:       return 32'h8000_0000;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    task automatic push_cfg(input logic [imm_pkg::DIM_W-1:0] v);
        t_load ld;
        ld = '{is_cfg: 1'b1, dim_val: v, row: '0, col: '0, a: '0, b: '0, done: 1'b0};
        plan_dim = v;
        load_q.push_back(ld);
    endtask

    task automatic push_load(input int row, input int col,
                             input logic [imm_pkg::VAL_W-1:0] a,
                             input logic [imm_pkg::VAL_W-1:0] b, input bit done);
        t_load ld;
        ld = '{is_cfg: 1'b0, dim_val: '0, row: imm_pkg::IDX_W'(row),
               col: imm_pkg::IDX_W'(col), a: a, b: b, done: done};
        planned[row * 8 + col] = 1'b1;
        n_loads++;
        load_q.push_back(ld);
    endtask

    // Queue one run at the planned dimension: a few random loads anywhere,
    // plus every element inside the active square not yet written, so the
    // product never reads an empty RAM entry. Shuffle and flag the final one.
    task automatic plan_run(input t_fill fill);
        int pos_q[$];
        int n;
        int extra;
        int k;
        int tmp;
        n     = eff_dim(plan_dim);
        extra = $urandom_range(0, 8);
        for (int i = 0; i < extra; i++) begin
            pos_q.push_back($urandom_range(0, 63));
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (!planned[i * 8 + j]) begin
                    pos_q.push_back(i * 8 + j);
                end
            end
        end
        if (pos_q.size() == 0) begin
            pos_q.push_back($urandom_range(0, 63));
        end
        for (int i = pos_q.size() - 1; i > 0; i--) begin
            k        = $urandom_range(0, i);
            tmp      = pos_q[i];
            pos_q[i] = pos_q[k];
            pos_q[k] = tmp;
        end
        foreach (pos_q[i]) begin
            push_load(pos_q[i] / 8, pos_q[i] % 8, rand_elem(fill), rand_elem(fill),
                      i == pos_q.size() - 1);
        end
    endtask

    // Store the beat; on the final beat queue every element of C row-major.
    // The exact sum is kept in 72 bits, enough for eight 64-bit products.
    task automatic compute_product(input t_load ld);
        int                 n;
        logic signed [71:0] acc;
        logic signed [71:0] ea;
        logic signed [71:0] eb;
        t_product           p;
        a_mem[{ld.row, ld.col}] = ld.a;
        b_mem[{ld.row, ld.col}] = ld.b;
        if (!ld.done) begin
            return;
        end
        n = eff_dim(dim_reg);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++) begin
                    ea  = $signed(a_mem[i * 8 + k]);
                    eb  = $signed(b_mem[k * 8 + j]);
                    acc = acc + ea * eb;
                end
                p.row   = imm_pkg::IDX_W'(i);
                p.col   = imm_pkg::IDX_W'(j);
                p.value = acc[31:0];
                // fits in 32 bits only if bits 71..31 all match the sign
                p.ovf   = !((&acc[71:31]) || !(|acc[71:31]));
                p.last  = (i == n - 1) && (j == n - 1);
                product_q.push_back(p);
            end
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [imm_pkg::VAL_W-1:0] want,
                                        input logic [imm_pkg::VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample both handshakes at the rising edge; predict accepted loads and
    // check accepted products against the oldest expectation.
    always @(posedge i_clk) begin
        t_product want;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                dim_reg = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                load_taken = 1'b1;
                compute_product(cur_load);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                product_taken = 1'b1;
                if (product_q.size() == 0) begin
                    $error("unexpected product beat: row %0d col %0d",
                           m_axis_tdata[2:0], m_axis_tdata[5:3]);
                    fail_count++;
                end else begin
                    want = product_q.pop_front();
                    check_field("out_row", imm_pkg::VAL_W'(want.row),
                                imm_pkg::VAL_W'(m_axis_tdata[2:0]));
                    check_field("out_col", imm_pkg::VAL_W'(want.col),
                                imm_pkg::VAL_W'(m_axis_tdata[5:3]));
                    check_field("product_value", want.value, m_axis_tdata[37:6]);
                    check_field("overflow", imm_pkg::VAL_W'(want.ovf),
                                imm_pkg::VAL_W'(m_axis_tuser));
                    check_field("last_out", imm_pkg::VAL_W'(want.last),
                                imm_pkg::VAL_W'(m_axis_tlast));
                end
            end
        end
    end

    // Driver: hold the offered beat until taken, then wait a random gap and
    // offer the next one. A dimension write waits until every product has
    // arrived and the block has sat idle a few cycles, then pulses once.
    always @(negedge i_clk) begin
        logic valid_nxt;
        logic cfg_en_nxt;
        valid_nxt  = s_axis_tvalid;
        cfg_en_nxt = 1'b0;
        if (load_taken) begin
            load_taken = 1'b0;
            valid_nxt  = 1'b0;
            if ($urandom_range(0, 29) == 0) begin
                tx_burst = !tx_burst;
            end
            tx_gap = draw_gap(tx_burst);
        end
        if (i_rst_n && !valid_nxt) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (load_q.size() > 0) begin
                if (load_q[0].is_cfg) begin
                    if (product_q.size() != 0) begin
                        settle_cnt = 0;
                    end else if (settle_cnt < SETTLE_CYCLES) begin
                        settle_cnt++;
                    end else begin
                        cfg_en_nxt    = 1'b1;
                        i_cfg_wr_data <= load_q[0].dim_val;
                        void'(load_q.pop_front());
                        settle_cnt    = 0;
                    end
                end else begin
                    cur_load     = load_q.pop_front();
                    s_axis_tdata <= {2'b00, cur_load.b, cur_load.a, cur_load.col, cur_load.row};
                    s_axis_tlast <= cur_load.done;
                    valid_nxt    = 1'b1;
                end
            end
        end
        s_axis_tvalid <= valid_nxt;
        i_cfg_wr_en   <= cfg_en_nxt;
    end

    // Receiver: after each product beat drop ready for a random number of
    // cycles; keep it low throughout a long hold-off.
    always @(negedge i_clk) begin
        logic rdy;
        if (product_taken) begin
            product_taken = 1'b0;
            if ($urandom_range(0, 29) == 0) begin
                rx_burst = !rx_burst;
            end
            rx_gap = draw_gap(rx_burst);
        end
        if (!i_rst_n || hold_left > 0) begin
            rdy = 1'b0;
        end else if (rx_gap > 0) begin
            rdy = 1'b0;
            rx_gap--;
        end else begin
            rdy = 1'b1;
        end
        m_axis_tready <= rdy;
    end

    // Long hold-off: twice during the run, right after a product beat,
    // stall the output while the sender keeps offering loads.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            hold_beats++;
            if (hold_beats == 20 || hold_beats == 400) begin
                hold_left = HOLD_CYCLES;
            end
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int first;
        int run_cnt;
        int r;
        t_fill fill;

        // Directed: a single element at the signed extremes and the exact
        // 32-bit boundaries, with a load outside the active square.
        push_cfg(4'd1);
        push_load(0, 0, 32'h8000_0000, 32'h0000_0001, 1'b1);
        push_load(0, 0, 32'h7fff_ffff, 32'h0000_0001, 1'b1);
        push_load(7, 7, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        push_load(0, 0, 32'h8000_0000, 32'h8000_0000, 1'b1);
        // Dimension zero acts as one; the final beat lands outside it.
        push_cfg(4'd0);
        push_load(0, 0, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        push_load(7, 0, 32'h1234_5678, 32'h9abc_def0, 1'b1);
        // 2x2: positive and negative overflow, and sums just inside range.
        push_cfg(4'd2);
        push_load(0, 0, 32'h7fff_ffff, 32'h0000_0001, 1'b0);
        push_load(0, 1, 32'h0000_0001, 32'h0000_0001, 1'b0);
        push_load(1, 0, 32'h8000_0000, 32'h0000_0001, 1'b0);
        push_load(1, 1, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        // 3x3 run that reuses the stored 2x2 corner.
        push_cfg(4'd3);
        plan_run(FILL_EDGE);

        // Random runs: mostly small dimensions, now and then the largest or
        // an out-of-range setting; some runs keep the previous dimension.
        first   = n_loads;
        run_cnt = 0;
        while (n_loads - first < RANDOM_ITEMS) begin
            if (run_cnt == 8) begin
                push_cfg(4'd15);
            end else if (run_cnt == 30) begin
                push_cfg(4'd8);
            end else if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    push_cfg(4'd0);
                end else if (r == 1) begin
                    push_cfg(imm_pkg::DIM_W'($urandom_range(9, 15)));
                end else if (r < 4) begin
                    push_cfg(imm_pkg::DIM_W'($urandom_range(5, 8)));
                end else begin
                    push_cfg(imm_pkg::DIM_W'($urandom_range(1, 4)));
                end
            end
            r = $urandom_range(0, 9);
            fill = (r < 5) ? FILL_SMALL : (r < 8) ? FILL_FULL : FILL_EDGE;
            plan_run(fill);
            run_cnt++;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the queue to empty and every product to arrive, then
        // watch a quiet stretch for stray beats.
        while (load_q.size() != 0 || s_axis_tvalid || product_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
